// File: src/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared constants and tables for the relative bearing sector unit.
// ----------------------------------------------------------------------------
package rbs_pkg;

  // Field widths of the input and result items
  localparam int TARGET_W = 26;
  localparam int OBS_W    = 34;
  localparam int HEAD_W   = 16;
  localparam int SECTOR_W = 6;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int FC_W    = 7;

  localparam logic [FC_W-1:0] FC_RESET = 7'd32;
  localparam logic [FC_W-1:0] FC_MIN   = 7'd1;
  localparam logic [FC_W-1:0] FC_MAX   = 7'd64;

  // Register index, taken from the word address bit of paddr
  localparam logic REG_FRAME_COUNT = 1'b0;

  // CORDIC angle accumulator: 2^32 steps per turn
  localparam int ANG_W    = 32;
  localparam int ATAN_LEN = 24;

  localparam logic [ANG_W-1:0] ANG_HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

endpackage

// File: src/rbs_stream_if.sv
// ----------------------------------------------------------------------------
// rbs_stream_if
// Valid/ready channels: input positions and heading, result sector index.
// ----------------------------------------------------------------------------
interface rbs_in_if;
  import rbs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [TARGET_W-1:0] target_x;
  logic signed [TARGET_W-1:0] target_z;
  logic signed [OBS_W-1:0]    observer_x;
  logic signed [OBS_W-1:0]    observer_z;
  logic        [HEAD_W-1:0]   heading;

  modport source (
    output valid, target_x, target_z, observer_x, observer_z, heading,
    input  ready
  );
  modport sink (
    input  valid, target_x, target_z, observer_x, observer_z, heading,
    output ready
  );
endinterface

interface rbs_out_if;
  import rbs_pkg::*;

  logic                valid;
  logic                ready;
  logic [SECTOR_W-1:0] sector_index;

  modport source (output valid, sector_index, input ready);
  modport sink   (input valid, sector_index, output ready);
endinterface

// File: src/rbs_cordic_stage.sv
// ----------------------------------------------------------------------------
// rbs_cordic_stage
// One registered vectoring CORDIC iteration with its own valid/ready slot.
// ----------------------------------------------------------------------------
module rbs_cordic_stage #(
  parameter int W      = 37,
  parameter int STEP   = 0,
  parameter int SIDE_W = 17
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic signed [W-1:0]        up_x,
  input  logic signed [W-1:0]        up_y,
  input  logic [rbs_pkg::ANG_W-1:0]  up_ang,
  input  logic [SIDE_W-1:0]          up_side,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output logic signed [W-1:0]        dn_x,
  output logic signed [W-1:0]        dn_y,
  output logic [rbs_pkg::ANG_W-1:0]  dn_ang,
  output logic [SIDE_W-1:0]          dn_side
);
  import rbs_pkg::*;

  logic signed [W-1:0]  x_next;
  logic signed [W-1:0]  y_next;
  logic [ANG_W-1:0]     ang_next;
  logic signed [W-1:0]  xs;
  logic signed [W-1:0]  ys;

  // Slot takes a new item when empty or when its item moves on
  assign up_ready = !dn_valid || dn_ready;

  // Rotate toward the x axis; y > 0 rotates clockwise
  always_comb begin
    xs = up_x >>> STEP;
    ys = up_y >>> STEP;
    if (up_y > 0) begin
      x_next   = up_x + ys;
      y_next   = up_y - xs;
      ang_next = up_ang + ATAN_TAB[STEP];
    end else begin
      x_next   = up_x - ys;
      y_next   = up_y + xs;
      ang_next = up_ang - ATAN_TAB[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_x    <= x_next;
      dn_y    <= y_next;
      dn_ang  <= ang_next;
      dn_side <= up_side;
    end
  end

endmodule

// File: src/relative_bearing_sector_unit.sv
// ----------------------------------------------------------------------------
// relative_bearing_sector_unit
// Bearing of target seen from observer, relative to heading, as a sector.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake             | Payload
//  --------+-----+-----------------------+----------------------------------
//  in_ch   | in  | valid/ready           | target_x/z, observer_x/z, heading
//  out_ch  | out | valid/ready           | sector_index
//  APB     | in  | psel/penable/pwrite   | frame_count at byte address 0
//
//  One item per cycle sustained while out_ch is ready; the registered stages are
//  offset, pre-rotation, one stage per CORDIC iteration, rounding, multiply.
//  Every stage has its own valid bit and takes an item when empty or when its
//  item moves on, so bubbles fill while out_ch is stalled.
//  rst is synchronous and clears all valid bits; frame_count resets to 32.
// ----------------------------------------------------------------------------
module relative_bearing_sector_unit #(
  parameter int CORDIC_STEPS           = 16,
  parameter int ANGLE_BITS             = 16,
  parameter int POSITION_FRACTION_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  rbs_in_if.sink                      in_ch,
  rbs_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbs_pkg::PADDR_W-1:0] paddr,
  input  logic [rbs_pkg::PDATA_W-1:0] pwdata,
  output logic [rbs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import rbs_pkg::*;

  localparam int AB     = ANGLE_BITS;
  localparam int N      = CORDIC_STEPS;
  localparam int TSH_W  = TARGET_W + POSITION_FRACTION_BITS;
  localparam int DW     = ((TSH_W > OBS_W) ? TSH_W : OBS_W) + 1;
  localparam int W      = DW + 2;
  localparam int HUP    = (AB >= HEAD_W) ? AB - HEAD_W : 0;
  localparam int HDN    = (AB < HEAD_W) ? HEAD_W - AB : 0;
  localparam int RSH    = ANG_W - AB;
  localparam int SIDE_W = AB + 1;
  localparam int PW     = AB + FC_W;

  localparam logic [ANG_W-1:0] ROUND_HALF = ANG_W'(1) << (RSH - 1);
  localparam logic [AB-1:0]    QUARTER    = AB'(1) << (AB - 2);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [FC_W-1:0] frame_count;
  logic            reg_sel;

  assign reg_sel = (paddr[PADDR_W-1] == REG_FRAME_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? PDATA_W'(frame_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FC_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      frame_count <= pwdata[FC_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage ready chain
  // --------------------------------------------------------------------------
  logic va, vb, vr, vm;
  logic ra, rb, rr, rm;
  logic c_valid [N+1];
  logic c_ready [N+1];

  assign rm          = !vm || out_ch.ready;
  assign rr          = !vr || rm;
  assign c_ready[N]  = rr;
  assign rb          = !vb || c_ready[0];
  assign ra          = !va || rb;
  assign in_ch.ready = ra;

  // --------------------------------------------------------------------------
  // Stage A: offset vector and heading at ANGLE_BITS
  // --------------------------------------------------------------------------
  logic signed [DW-1:0]     dx_next, dz_next;
  logic [HEAD_W+HUP-1:0]    head_wide;
  logic signed [DW-1:0]     a_dx, a_dz;
  logic [AB-1:0]            a_head;

  assign dx_next   = (DW'(in_ch.target_x) <<< POSITION_FRACTION_BITS)
                     - DW'(in_ch.observer_x);
  assign dz_next   = (DW'(in_ch.target_z) <<< POSITION_FRACTION_BITS)
                     - DW'(in_ch.observer_z);
  assign head_wide = (HEAD_W + HUP)'(in_ch.heading) << HUP;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ra) begin
      va <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ra) begin
      a_dx   <= dx_next;
      a_dz   <= dz_next;
      a_head <= AB'(head_wide >> HDN);
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: zero test, fold left half plane onto the right
  // --------------------------------------------------------------------------
  logic signed [W-1:0] cx   [N+1];
  logic signed [W-1:0] cy   [N+1];
  logic [ANG_W-1:0]    cang [N+1];
  logic [SIDE_W-1:0]   cside[N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rb) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rb) begin
      if (a_dx < 0) begin
        cx[0]   <= -W'(a_dx);
        cy[0]   <= -W'(a_dz);
        cang[0] <= ANG_HALF_TURN;
      end else begin
        cx[0]   <= W'(a_dx);
        cy[0]   <= W'(a_dz);
        cang[0] <= '0;
      end
      cside[0] <= {(a_dx == '0) && (a_dz == '0), a_head};
    end
  end

  assign c_valid[0] = vb;

  // --------------------------------------------------------------------------
  // CORDIC iterations, one register stage each
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < N; k++) begin : g_cordic
    rbs_cordic_stage #(
      .W      (W),
      .STEP   (k),
      .SIDE_W (SIDE_W)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (c_valid[k]),
      .up_ready (c_ready[k]),
      .up_x     (cx[k]),
      .up_y     (cy[k]),
      .up_ang   (cang[k]),
      .up_side  (cside[k]),
      .dn_valid (c_valid[k+1]),
      .dn_ready (c_ready[k+1]),
      .dn_x     (cx[k+1]),
      .dn_y     (cy[k+1]),
      .dn_ang   (cang[k+1]),
      .dn_side  (cside[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage R: round bearing, subtract heading, add quarter turn
  // --------------------------------------------------------------------------
  logic [ANG_W-1:0] rounded;
  logic [AB-1:0]    bearing;
  logic             zero_off;
  logic [AB-1:0]    head_r;
  logic [AB-1:0]    r_rel;

  assign {zero_off, head_r} = cside[N];
  assign rounded = cang[N] + ROUND_HALF;
  assign bearing = zero_off ? '0 : rounded[ANG_W-1:RSH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (rr) begin
      vr <= c_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (rr) begin
      r_rel <= bearing - head_r + QUARTER;
    end
  end

  // --------------------------------------------------------------------------
  // Stage M: scale by sector count, keep the integer part
  // --------------------------------------------------------------------------
  logic [FC_W-1:0] fc_eff;
  logic [PW-1:0]   prod;

  always_comb begin
    priority if (frame_count == '0) begin
      fc_eff = FC_MIN;
    end else if (frame_count > FC_MAX) begin
      fc_eff = FC_MAX;
    end else begin
      fc_eff = frame_count;
    end
  end

  assign prod = PW'(r_rel) * PW'(fc_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (rm) begin
      vm <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (rm) begin
      out_ch.sector_index <= prod[AB+SECTOR_W-1:AB];
    end
  end

  assign out_ch.valid = vm;

endmodule

// File: dv/rbs_sector_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rbs_sector_checker
// Watches the item channels and the register port of the bearing sector unit,
// computes the sector of every accepted item on its own and compares it, in
// order, with the results the unit delivers.
// ----------------------------------------------------------------------------
module rbs_sector_checker (
  input  logic                        clk,
  input  logic                        rst,
  rbs_in_if                           in_ch,
  rbs_out_if                          out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [rbs_pkg::PADDR_W-1:0] paddr,
  input  logic [rbs_pkg::PDATA_W-1:0] pwdata,
  output int                          mismatches,
  output int                          outstanding
);
  import rbs_pkg::*;

  // Build of the unit under test
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int POS_FRAC     = 8;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic signed [TARGET_W-1:0] tx;
    logic signed [TARGET_W-1:0] tz;
    logic signed [OBS_W-1:0]    ox;
    logic signed [OBS_W-1:0]    oz;
    logic [HEAD_W-1:0]          hd;
    logic [SECTOR_W-1:0]        sector;
  } pending_sector_t;

  pending_sector_t  pending_sectors[$];
  logic [FC_W-1:0]  frame_count;

  // Sector of the target bearing, relative to the heading
  function automatic logic [SECTOR_W-1:0] sector_of(
    input logic signed [TARGET_W-1:0] tx,
    input logic signed [TARGET_W-1:0] tz,
    input logic signed [OBS_W-1:0]    ox,
    input logic signed [OBS_W-1:0]    oz,
    input logic [HEAD_W-1:0]          hd,
    input logic [FC_W-1:0]            fc
  );
    longint                        dx;
    longint                        dz;
    longint                        x;
    longint                        y;
    longint                        xs;
    longint                        ys;
    logic [ANG_W-1:0]              ang;
    logic [ANG_W:0]                rounded;
    logic [ANGLE_BITS-1:0]         bearing;
    logic [ANGLE_BITS-1:0]         rel;
    logic [FC_W-1:0]               sectors;
    logic [ANGLE_BITS+FC_W-1:0]    scaled;
    dx = (longint'(tx) <<< POS_FRAC) - longint'(ox);
    dz = (longint'(tz) <<< POS_FRAC) - longint'(oz);
    bearing = '0;
    if (dx != 0 || dz != 0) begin
      x   = dx;
      y   = dz;
      ang = '0;
      // left half plane: rotate by half a turn first
      if (x < 0) begin
        x   = -x;
        y   = -y;
        ang = ANG_HALF_TURN;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x   = x + ys;
          y   = y - xs;
          ang = ang + ATAN_TAB[i];
        end else begin
          x   = x - ys;
          y   = y + xs;
          ang = ang - ATAN_TAB[i];
        end
      end
      // round half up to the angle width, wrap at one turn
      rounded = {1'b0, ang} + ((ANG_W+1)'(1) << (ANG_W - ANGLE_BITS - 1));
      bearing = rounded[ANG_W-1 -: ANGLE_BITS];
    end
    // heading has the same width as the angle here
    rel     = bearing - hd + (ANGLE_BITS'(1) << (ANGLE_BITS - 2));
    sectors = (fc == '0) ? FC_MIN : (fc > FC_MAX) ? FC_MAX : fc;
    scaled  = rel * sectors;
    return scaled[ANGLE_BITS +: SECTOR_W];
  endfunction

  // Register snoop, prediction on input, in-order compare on output
  always @(posedge clk) begin
    pending_sector_t item;
    if (rst) begin
      pending_sectors.delete();
      frame_count = FC_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_COUNT)
        frame_count = pwdata[FC_W-1:0];

      if (in_ch.valid && in_ch.ready) begin
        item.tx     = in_ch.target_x;
        item.tz     = in_ch.target_z;
        item.ox     = in_ch.observer_x;
        item.oz     = in_ch.observer_z;
        item.hd     = in_ch.heading;
        item.sector = sector_of(item.tx, item.tz, item.ox, item.oz, item.hd,
                                frame_count);
        pending_sectors.push_back(item);
      end

      if (out_ch.valid && out_ch.ready) begin
        if (pending_sectors.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: unexpected sector %0d with no item outstanding",
                     $realtime, out_ch.sector_index);
          mismatches <= mismatches + 1;
        end else begin
          item = pending_sectors.pop_front();
          if (out_ch.sector_index !== item.sector) begin
            if (mismatches < REPORT_MAX)
              $display(
                "%0t: sector exp %0d got %0d (tx %0d tz %0d ox %0d oz %0d hd %0d fc %0d)",
                $realtime, item.sector, out_ch.sector_index, item.tx,
                item.tz, item.ox, item.oz, item.hd, frame_count);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    outstanding <= pending_sectors.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the relative bearing sector unit: a directed set of corner
// positions and headings, then random items over several sector counts,
// with random gaps on both channels and one burst at full rate.
// ----------------------------------------------------------------------------
module tb;
  import rbs_pkg::*;

  localparam int PHASE_ITEMS  = 65;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 32;
  localparam int FULL_RATE_PH = 4;

  localparam logic signed [TARGET_W-1:0] TGT_MAX = {1'b0, {(TARGET_W-1){1'b1}}};
  localparam logic signed [TARGET_W-1:0] TGT_MIN = {1'b1, {(TARGET_W-1){1'b0}}};
  localparam logic signed [OBS_W-1:0]    OBS_MAX = {1'b0, {(OBS_W-1){1'b1}}};
  localparam logic signed [OBS_W-1:0]    OBS_MIN = {1'b1, {(OBS_W-1){1'b0}}};

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               no_idle;
  int                 mismatches;
  int                 outstanding;

  rbs_in_if  in_ch ();
  rbs_out_if out_ch ();

  relative_bearing_sector_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rbs_sector_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Clock
  always #1 clk = ~clk;

  // Result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Run limit
  initial begin
    #1ms;
    $display("tb: errors");
    $finish;
  end

  // Drive one item, with a random gap in front, and hold it until accepted
  task automatic push_item(
    input logic signed [TARGET_W-1:0] tx,
    input logic signed [TARGET_W-1:0] tz,
    input logic signed [OBS_W-1:0]    ox,
    input logic signed [OBS_W-1:0]    oz,
    input logic [HEAD_W-1:0]          hd
  );
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.target_x   <= tx;
    in_ch.target_z   <= tz;
    in_ch.observer_x <= ox;
    in_ch.observer_z <= oz;
    in_ch.heading    <= hd;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and wait until every result is back
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_frame_count(input logic [FC_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FRAME_COUNT, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [TARGET_W-1:0] pick_target();
    case ($urandom_range(5))
      0:       return TGT_MIN;
      1:       return TGT_MAX;
      2:       return '0;
      3:       return '1;
      4:       return TARGET_W'(1);
      default: return TARGET_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [OBS_W-1:0] pick_observer();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      0:       return OBS_MIN;
      1:       return OBS_MAX;
      2:       return '0;
      3:       return '1;
      4:       return OBS_W'(1);
      default: return r[OBS_W-1:0];
    endcase
  endfunction

  // Random item: wide random, observer close to target, axes and diagonals,
  // or field extremes
  task automatic random_item();
    logic [63:0]                r;
    logic signed [TARGET_W-1:0] tx;
    logic signed [TARGET_W-1:0] tz;
    logic signed [OBS_W-1:0]    ox;
    logic signed [OBS_W-1:0]    oz;
    logic [HEAD_W-1:0]          hd;
    int                         k;
    int                         pct;
    pct = $urandom_range(99);
    if (pct < 35) begin
      r  = {$urandom, $urandom};
      ox = r[OBS_W-1:0];
      r  = {$urandom, $urandom};
      oz = r[OBS_W-1:0];
      tx = TARGET_W'($urandom);
      tz = TARGET_W'($urandom);
    end else if (pct < 65) begin
      k  = int'($urandom_range(2097151)) - 1048576;
      tx = TARGET_W'(k);
      k  = int'($urandom_range(2097151)) - 1048576;
      tz = TARGET_W'(k);
      ox = OBS_W'(tx);
      oz = OBS_W'(tz);
      ox = (ox <<< 8) + OBS_W'(($urandom_range(9) == 0) ? 0
                                : int'($urandom_range(2000)) - 1000);
      oz = (oz <<< 8) + OBS_W'(($urandom_range(9) == 0) ? 0
                                : int'($urandom_range(2000)) - 1000);
    end else if (pct < 80) begin
      k  = int'($urandom_range(8388607)) - 4194304;
      ox = '0;
      oz = '0;
      case ($urandom_range(3))
        0:       begin tx = TARGET_W'(k); tz = '0;            end
        1:       begin tx = '0;           tz = TARGET_W'(k);  end
        2:       begin tx = TARGET_W'(k); tz = TARGET_W'(k);  end
        default: begin tx = TARGET_W'(k); tz = TARGET_W'(-k); end
      endcase
    end else begin
      tx = pick_target();
      tz = pick_target();
      ox = pick_observer();
      oz = pick_observer();
    end
    case ($urandom_range(9))
      0:       hd = '0;
      1:       hd = '1;
      2:       hd = 16'h4000;
      3:       hd = 16'h8000;
      default: hd = HEAD_W'($urandom);
    endcase
    push_item(tx, tz, ox, oz, hd);
  endtask

  // Main sequence
  initial begin
    logic [FC_W-1:0] phase_counts [10];
    clk              = 1'b0;
    rst              = 1'b1;
    no_idle          = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.target_x   = '0;
    in_ch.target_z   = '0;
    in_ch.observer_x = '0;
    in_ch.observer_z = '0;
    in_ch.heading    = '0;
    out_ch.ready     = 1'b0;
    phase_counts     = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd63,
                         7'd3, 7'd17, 7'd32};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners at the reset sector count
    push_item('0, '0, '0, '0, '0);                                // zero offset
    push_item(26'sd5, -26'sd7, 34'sd1280, -34'sd1792, 16'h1234);  // zero offset
    push_item(26'sd1, '0, '0, '0, '0);                            // +x axis
    push_item(-26'sd1, '0, '0, '0, '0);                           // -x axis
    push_item('0, 26'sd1, '0, '0, '0);                            // +z axis
    push_item('0, -26'sd1, '0, '0, '0);                           // -z axis
    push_item('0, '0, 34'sd1, '0, 16'h8000);                      // one fraction lsb
    push_item('0, '0, '0, -34'sd1, 16'hFFFF);
    push_item(26'sd3, 26'sd3, '0, '0, '0);                        // diagonals
    push_item(-26'sd3, 26'sd3, '0, '0, 16'h4000);
    push_item(26'sd3, -26'sd3, '0, '0, 16'hC000);
    push_item(-26'sd3, -26'sd3, '0, '0, 16'h0001);
    push_item(TGT_MAX, TGT_MAX, OBS_MIN, OBS_MIN, 16'hFFFF);      // largest offset
    push_item(TGT_MIN, TGT_MIN, OBS_MAX, OBS_MAX, 16'h8000);
    push_item(TGT_MAX, TGT_MIN, OBS_MIN, OBS_MAX, 16'h0001);
    push_item(TGT_MIN, TGT_MAX, OBS_MAX, OBS_MIN, 16'h4000);
    push_item('0, '0, OBS_MAX, '0, 16'h7FFF);
    push_item('0, '0, '0, OBS_MIN, '0);
    push_item(26'sd10, '0, '0, '0, 16'hC000);

    // Random items over several sector counts, one phase at full rate
    foreach (phase_counts[p]) begin
      drain();
      write_frame_count((p >= 7) ? FC_W'($urandom_range(127)) : phase_counts[p]);
      no_idle = (p == FULL_RATE_PH);
      repeat (PHASE_ITEMS) random_item();
    end
    no_idle = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
